[rtl/core/hhbp_pkg.sv]
// Package for the HTTP header byte parser: widths, codes and result type.
package hhbp_pkg;

  // Length counter geometry
  localparam int unsigned LENGTH_BITS = 10;
  localparam int unsigned COUNT_BITS  = LENGTH_BITS + 1;

  // Configuration port geometry
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam logic        REG_MAX_KEY   = 1'b0;
  localparam logic        REG_MAX_VALUE = 1'b1;
  localparam logic [LENGTH_BITS-1:0] LIMIT_RESET = LENGTH_BITS'(255);

  // Byte roles
  localparam logic [3:0] ROLE_SKIP    = 4'd0;
  localparam logic [3:0] ROLE_KEY     = 4'd1;
  localparam logic [3:0] ROLE_COLON   = 4'd2;
  localparam logic [3:0] ROLE_SPACE   = 4'd3;
  localparam logic [3:0] ROLE_VALUE   = 4'd4;
  localparam logic [3:0] ROLE_LINE_CR = 4'd5;
  localparam logic [3:0] ROLE_LINE_LF = 4'd6;
  localparam logic [3:0] ROLE_END_CR  = 4'd7;
  localparam logic [3:0] ROLE_END_LF  = 4'd8;
  localparam logic [3:0] ROLE_BODY    = 4'd9;

  // Parse status
  localparam logic [1:0] ST_NEED_MORE = 2'd0;
  localparam logic [1:0] ST_ENDED     = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  // Error causes
  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_KEY_LONG  = 3'd1;
  localparam logic [2:0] CAUSE_NO_SPACE  = 3'd2;
  localparam logic [2:0] CAUSE_BAD_CRLF  = 3'd3;
  localparam logic [2:0] CAUSE_VAL_LONG  = 3'd4;
  localparam logic [2:0] CAUSE_CR_NO_LF  = 3'd5;

  // Characters
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // One result item
  typedef struct packed {
    logic [7:0]             byte_echo;
    logic [3:0]             byte_role;
    logic                   pair_complete;
    logic [LENGTH_BITS-1:0] key_length;
    logic [LENGTH_BITS-1:0] value_length;
    logic [1:0]             parse_status;
    logic [2:0]             error_cause;
  } result_t;

  // Length limits from the register file
  typedef struct packed {
    logic [LENGTH_BITS-1:0] max_key_length;
    logic [LENGTH_BITS-1:0] max_value_length;
  } limits_t;

endpackage

[rtl/core/hhbp_if.sv]
// Stream interfaces for the parser's input bytes and result items.
interface hhbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_block;

  modport source (output valid, output data_byte, output first_of_block, input ready);
  modport sink   (input valid, input data_byte, input first_of_block, output ready);
endinterface

interface hhbp_out_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      byte_echo;
  logic [3:0]                      byte_role;
  logic                            pair_complete;
  logic [hhbp_pkg::LENGTH_BITS-1:0] key_length;
  logic [hhbp_pkg::LENGTH_BITS-1:0] value_length;
  logic [1:0]                      parse_status;
  logic [2:0]                      error_cause;

  modport source (output valid, output byte_echo, output byte_role, output pair_complete,
                  output key_length, output value_length, output parse_status,
                  output error_cause, input ready);
  modport sink   (input valid, input byte_echo, input byte_role, input pair_complete,
                  input key_length, input value_length, input parse_status,
                  input error_cause, output ready);
endinterface

[rtl/core/http_header_byte_parser_unit.sv]
// A byte accepted into the input register passes to the result register when that is free.
// Throughput: one byte per clock while out_m.ready stays high; input and result registers
// are separate stages, so one more byte is taken while a finished result waits for ready.
// The parse state updates as a byte moves from the input register to the result register.
// Reset (rst_ni low, async): pipeline empty, parser at block start, both limits 255.
module http_header_byte_parser_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  hhbp_in_if.sink                            in_s,
  hhbp_out_if.source                         out_m,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hhbp_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [hhbp_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [hhbp_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  hhbp_pkg::limits_t limits;
  hhbp_pkg::result_t step_res;
  hhbp_pkg::result_t res_q;
  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              in_first_q;
  logic              out_vld_q;
  logic              out_free;
  logic              advance;

  hhbp_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .limits_o  (limits)
  );

  hhbp_parse_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .data_byte_i      (in_byte_q),
    .first_of_block_i (in_first_q),
    .limits_i         (limits),
    .result_o         (step_res)
  );

  // Handshake between the two stages
  assign out_free  = !out_vld_q || out_m.ready;
  assign advance   = in_vld_q && out_free;
  assign in_s.ready = !in_vld_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_s.ready) begin
      in_vld_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.ready && in_s.valid) begin
      in_byte_q  <= in_s.data_byte;
      in_first_q <= in_s.first_of_block;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_m.valid         = out_vld_q;
  assign out_m.byte_echo     = res_q.byte_echo;
  assign out_m.byte_role     = res_q.byte_role;
  assign out_m.pair_complete = res_q.pair_complete;
  assign out_m.key_length    = res_q.key_length;
  assign out_m.value_length  = res_q.value_length;
  assign out_m.parse_status  = res_q.parse_status;
  assign out_m.error_cause   = res_q.error_cause;

endmodule

[rtl/core/hhbp_cfg_regs.sv]
// APB register file holding the key and value length limits.
module hhbp_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [hhbp_pkg::CFG_ADDR_BITS-1:0]  paddr_i,
  input  logic [hhbp_pkg::CFG_DATA_BITS-1:0]  pwdata_i,
  output logic [hhbp_pkg::CFG_DATA_BITS-1:0]  prdata_o,
  output logic                                pready_o,
  output hhbp_pkg::limits_t                   limits_o
);

  logic [hhbp_pkg::LENGTH_BITS-1:0] max_key_q;
  logic [hhbp_pkg::LENGTH_BITS-1:0] max_value_q;
  logic                             wr_en;
  logic                             reg_sel;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign reg_sel  = paddr_i[2];

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_key_q   <= hhbp_pkg::LIMIT_RESET;
      max_value_q <= hhbp_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        hhbp_pkg::REG_MAX_KEY:   max_key_q   <= pwdata_i[hhbp_pkg::LENGTH_BITS-1:0];
        hhbp_pkg::REG_MAX_VALUE: max_value_q <= pwdata_i[hhbp_pkg::LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      hhbp_pkg::REG_MAX_KEY:
        prdata_o = {{(hhbp_pkg::CFG_DATA_BITS-hhbp_pkg::LENGTH_BITS){1'b0}}, max_key_q};
      default:
        prdata_o = {{(hhbp_pkg::CFG_DATA_BITS-hhbp_pkg::LENGTH_BITS){1'b0}}, max_value_q};
    endcase
  end

  assign limits_o.max_key_length   = max_key_q;
  assign limits_o.max_value_length = max_value_q;

endmodule

[rtl/core/hhbp_parse_core.sv]
// Parse state, length counters and the per-byte next-state logic.
module hhbp_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_of_block_i,
  input  hhbp_pkg::limits_t limits_i,
  output hhbp_pkg::result_t result_o
);

  localparam int unsigned CB = hhbp_pkg::COUNT_BITS;
  localparam int unsigned LB = hhbp_pkg::LENGTH_BITS;
  localparam logic [CB-1:0] CNT_MAX = '1;
  localparam logic [CB-1:0] CNT_ONE = CB'(1);

  // Phase codes
  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_KEY   = 4'd1;
  localparam logic [3:0] PH_COLON = 4'd2;
  localparam logic [3:0] PH_SPACE = 4'd3;
  localparam logic [3:0] PH_VALUE = 4'd4;
  localparam logic [3:0] PH_CR    = 4'd5;
  localparam logic [3:0] PH_LF    = 4'd6;
  localparam logic [3:0] PH_ENDCR = 4'd7;
  localparam logic [3:0] PH_ENDLF = 4'd8;

  logic [3:0]    phase_q, phase_d, phase_c;
  logic [CB-1:0] key_cnt_q, key_cnt_d, key_cnt_c;
  logic [CB-1:0] val_cnt_q, val_cnt_d, val_cnt_c;
  logic [1:0]    status_q, status_d, status_c;
  logic [2:0]    cause_q, cause_d, cause_c;
  logic [3:0]    role;
  logic          pair;
  logic          is_crlf;
  logic          key_long;
  logic          val_long;

  assign is_crlf  = (data_byte_i == hhbp_pkg::CHAR_CR) || (data_byte_i == hhbp_pkg::CHAR_LF);

  // Block start returns the parse state to reset before this byte
  always_comb begin
    if (first_of_block_i) begin
      phase_c   = PH_START;
      key_cnt_c = '0;
      val_cnt_c = '0;
      status_c  = hhbp_pkg::ST_NEED_MORE;
      cause_c   = hhbp_pkg::CAUSE_NONE;
    end else begin
      phase_c   = phase_q;
      key_cnt_c = key_cnt_q;
      val_cnt_c = val_cnt_q;
      status_c  = status_q;
      cause_c   = cause_q;
    end
  end

  assign key_long = key_cnt_c > {1'b0, limits_i.max_key_length};
  assign val_long = val_cnt_c > {1'b0, limits_i.max_value_length};

  // Per-byte transition
  always_comb begin
    phase_d   = phase_c;
    key_cnt_d = key_cnt_c;
    val_cnt_d = val_cnt_c;
    status_d  = status_c;
    cause_d   = cause_c;
    role      = hhbp_pkg::ROLE_SKIP;
    pair      = 1'b0;
    if (status_c != hhbp_pkg::ST_ERROR) begin
      unique case (phase_c)
        PH_START: begin
          if (!is_crlf) begin
            role      = hhbp_pkg::ROLE_KEY;
            key_cnt_d = CNT_ONE;
            val_cnt_d = '0;
            phase_d   = PH_KEY;
          end
        end
        PH_KEY: begin
          if (data_byte_i == hhbp_pkg::CHAR_COLON) begin
            if ((key_cnt_c == '0) || key_long) begin
              status_d = hhbp_pkg::ST_ERROR;
              cause_d  = hhbp_pkg::CAUSE_KEY_LONG;
            end else begin
              role    = hhbp_pkg::ROLE_COLON;
              phase_d = PH_COLON;
            end
          end else if (is_crlf) begin
            status_d = hhbp_pkg::ST_ERROR;
            cause_d  = hhbp_pkg::CAUSE_BAD_CRLF;
          end else begin
            role      = hhbp_pkg::ROLE_KEY;
            key_cnt_d = (key_cnt_c != CNT_MAX) ? key_cnt_c + CNT_ONE : key_cnt_c;
          end
        end
        PH_COLON: begin
          if (data_byte_i == hhbp_pkg::CHAR_SPACE) begin
            role    = hhbp_pkg::ROLE_SPACE;
            phase_d = PH_SPACE;
          end else begin
            status_d = hhbp_pkg::ST_ERROR;
            cause_d  = hhbp_pkg::CAUSE_NO_SPACE;
          end
        end
        PH_SPACE: begin
          if (is_crlf) begin
            status_d = hhbp_pkg::ST_ERROR;
            cause_d  = hhbp_pkg::CAUSE_BAD_CRLF;
          end else begin
            role      = hhbp_pkg::ROLE_VALUE;
            val_cnt_d = CNT_ONE;
            phase_d   = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (data_byte_i == hhbp_pkg::CHAR_CR) begin
            if ((val_cnt_c == '0) || val_long) begin
              status_d = hhbp_pkg::ST_ERROR;
              cause_d  = hhbp_pkg::CAUSE_VAL_LONG;
            end else begin
              role    = hhbp_pkg::ROLE_LINE_CR;
              phase_d = PH_CR;
            end
          end else if (val_long) begin
            status_d = hhbp_pkg::ST_ERROR;
            cause_d  = hhbp_pkg::CAUSE_VAL_LONG;
          end else begin
            role      = hhbp_pkg::ROLE_VALUE;
            val_cnt_d = (val_cnt_c != CNT_MAX) ? val_cnt_c + CNT_ONE : val_cnt_c;
          end
        end
        PH_CR: begin
          if (data_byte_i == hhbp_pkg::CHAR_LF) begin
            role    = hhbp_pkg::ROLE_LINE_LF;
            pair    = 1'b1;
            phase_d = PH_LF;
          end else begin
            status_d = hhbp_pkg::ST_ERROR;
            cause_d  = hhbp_pkg::CAUSE_CR_NO_LF;
          end
        end
        PH_LF: begin
          if (data_byte_i == hhbp_pkg::CHAR_CR) begin
            role    = hhbp_pkg::ROLE_END_CR;
            phase_d = PH_ENDCR;
          end else if (data_byte_i == hhbp_pkg::CHAR_LF) begin
            status_d = hhbp_pkg::ST_ERROR;
            cause_d  = hhbp_pkg::CAUSE_BAD_CRLF;
          end else begin
            role      = hhbp_pkg::ROLE_KEY;
            key_cnt_d = CNT_ONE;
            val_cnt_d = '0;
            phase_d   = PH_KEY;
          end
        end
        PH_ENDCR: begin
          if (data_byte_i == hhbp_pkg::CHAR_LF) begin
            role     = hhbp_pkg::ROLE_END_LF;
            phase_d  = PH_ENDLF;
            status_d = hhbp_pkg::ST_ENDED;
          end else begin
            status_d = hhbp_pkg::ST_ERROR;
            cause_d  = hhbp_pkg::CAUSE_CR_NO_LF;
          end
        end
        default: begin
          // After the blank line everything is body
          role     = hhbp_pkg::ROLE_BODY;
          phase_d  = PH_ENDLF;
          status_d = hhbp_pkg::ST_ENDED;
        end
      endcase
    end
  end

  // State update on each parsed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      key_cnt_q <= '0;
      val_cnt_q <= '0;
      status_q  <= hhbp_pkg::ST_NEED_MORE;
      cause_q   <= hhbp_pkg::CAUSE_NONE;
    end else if (step_i) begin
      phase_q   <= phase_d;
      key_cnt_q <= key_cnt_d;
      val_cnt_q <= val_cnt_d;
      status_q  <= status_d;
      cause_q   <= cause_d;
    end
  end

  // Result, lengths saturated to the output width
  assign result_o.byte_echo     = data_byte_i;
  assign result_o.byte_role     = role;
  assign result_o.pair_complete = pair;
  assign result_o.key_length    = key_cnt_d[LB] ? '1 : key_cnt_d[LB-1:0];
  assign result_o.value_length  = val_cnt_d[LB] ? '1 : val_cnt_d[LB-1:0];
  assign result_o.parse_status  = status_d;
  assign result_o.error_cause   = cause_d;

endmodule
